### design/shd_pkg.sv
// ============================================================================
// shd_pkg
// Shared types, constants and the control store of the sensor history
// decimator.
// ============================================================================
package shd_pkg;

    localparam int DEPTH     = 15;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CO2_W     = 14;
    localparam int PCT_W     = 7;
    localparam int PER_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 4;

    // sums of all entries and the reciprocal used for the mean
    localparam int SUM_LOG    = $clog2(DEPTH);
    localparam int CO2_SUM_W  = CO2_W + SUM_LOG;
    localparam int PCT_SUM_W  = PCT_W + SUM_LOG;
    localparam int RCP_SH     = CO2_SUM_W + SUM_LOG + 1;
    localparam int RCP_W      = RCP_SH + 1;
    localparam int PROD_CO2_W = CO2_SUM_W + RCP_W;
    localparam int PROD_PCT_W = PCT_SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'((2 ** RCP_SH + DEPTH - 1) / DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_PERIOD   = CFG_IDX_W'(1);
    localparam logic [PER_W-1:0]     MINUTE_PERIOD_RST = PER_W'(4);
    localparam logic [PER_W-1:0]     HOUR_PERIOD_RST   = PER_W'(60);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // program addresses
    localparam logic [STEP_W-1:0] S_IDLE      = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_DISPATCH  = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_MIN_CHK   = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_MIN_PUSH  = STEP_W'(3);
    localparam logic [STEP_W-1:0] S_HOUR_CHK  = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_SUM       = STEP_W'(5);
    localparam logic [STEP_W-1:0] S_DIV       = STEP_W'(6);
    localparam logic [STEP_W-1:0] S_HOUR_PUSH = STEP_W'(7);
    localparam logic [STEP_W-1:0] S_TICK_OUT  = STEP_W'(8);
    localparam logic [STEP_W-1:0] S_READ_OUT  = STEP_W'(9);

    typedef struct packed {
        logic             op;
        logic [CO2_W-1:0] co2_ppm;
        logic [PCT_W-1:0] humidity_pct;
        logic [PCT_W-1:0] temp_magnitude;
        logic             temp_negative;
        logic             read_long_term;
        logic [3:0]       read_index;
    } t_in_beat;

    typedef struct packed {
        logic [CO2_W-1:0] co2_out;
        logic [PCT_W-1:0] humidity_out;
        logic [PCT_W-1:0] temperature_out;
        logic             minute_stored;
        logic             hour_stored;
    } t_out_beat;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_BEAT,
        C_IS_READ,
        C_NO_MIN,
        C_NO_HOUR,
        C_SUM_MORE
    } t_cond;

    typedef struct packed {
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              shift_short;
        logic              sum_clr;
        logic              sum_acc;
        logic              mul;
        logic              shift_long;
        logic              emit;
        logic              emit_read;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic is_read;
        logic mstore;
        logic hstore;
        logic sum_last;
        logic out_busy;
    } t_stat;

    function automatic t_ctrl f_ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w      = '0;
        w.cond = C_NEXT;
        case (step)
            S_IDLE: begin
                w.cond   = C_NO_BEAT;
                w.target = S_IDLE;
            end
            S_DISPATCH: begin
                w.cond   = C_IS_READ;
                w.target = S_READ_OUT;
            end
            S_MIN_CHK: begin
                w.cond   = C_NO_MIN;
                w.target = S_HOUR_CHK;
            end
            S_MIN_PUSH: begin
                w.shift_short = 1'b1;
            end
            S_HOUR_CHK: begin
                w.cond    = C_NO_HOUR;
                w.target  = S_TICK_OUT;
                w.sum_clr = 1'b1;
            end
            S_SUM: begin
                w.cond    = C_SUM_MORE;
                w.target  = S_SUM;
                w.sum_acc = 1'b1;
            end
            S_DIV: begin
                w.mul = 1'b1;
            end
            S_HOUR_PUSH: begin
                w.shift_long = 1'b1;
            end
            S_TICK_OUT: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
                w.emit   = 1'b1;
            end
            S_READ_OUT: begin
                w.cond      = C_ALWAYS;
                w.target    = S_IDLE;
                w.emit      = 1'b1;
                w.emit_read = 1'b1;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### design/shd_sequencer.sv
// ============================================================================
// shd_sequencer
// Step counter over the control store, with conditional jumps on datapath
// status and a hold while a result cannot be handed over.
// ============================================================================
module shd_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  shd_pkg::t_stat i_stat,
    output shd_pkg::t_ctrl o_ctrl
);

    logic [shd_pkg::STEP_W-1:0] r_step;
    logic [shd_pkg::STEP_W-1:0] n_step;
    shd_pkg::t_ctrl             ctrl;
    logic                       take;
    logic                       hold;

    assign ctrl   = shd_pkg::f_ucode(r_step);
    assign o_ctrl = ctrl;

    always_comb begin
        case (ctrl.cond)
            shd_pkg::C_NEXT:     take = 1'b0;
            shd_pkg::C_ALWAYS:   take = 1'b1;
            shd_pkg::C_NO_BEAT:  take = !i_stat.in_fire;
            shd_pkg::C_IS_READ:  take = i_stat.is_read;
            shd_pkg::C_NO_MIN:   take = !i_stat.mstore;
            shd_pkg::C_NO_HOUR:  take = !i_stat.hstore;
            shd_pkg::C_SUM_MORE: take = !i_stat.sum_last;
            default:             take = 1'b0;
        endcase
    end

    assign hold = ctrl.emit && i_stat.out_busy;

    always_comb begin
        if (hold) begin
            n_step = r_step;
        end else if (take) begin
            n_step = ctrl.target;
        end else begin
            n_step = r_step + shd_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= shd_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### design/shd_datapath.sv
// ============================================================================
// shd_datapath
// Period counters, the six history shift lines, the serial summer, the
// reciprocal divider and the output register.
// ============================================================================
module shd_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  shd_pkg::t_ctrl                    i_ctrl,
    input  logic                              i_in_fire,
    input  shd_pkg::t_in_beat                 i_in_beat,
    input  logic                              i_cfg_we,
    input  logic [shd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [shd_pkg::PER_W-1:0]         i_cfg_data,
    input  logic                              i_out_stall,
    output shd_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    output shd_pkg::t_out_beat                o_out_beat
);

    localparam int DEPTH = shd_pkg::DEPTH;
    localparam int IDX_W = shd_pkg::IDX_W;
    localparam int CO2_W = shd_pkg::CO2_W;
    localparam int PCT_W = shd_pkg::PCT_W;
    localparam int PER_W = shd_pkg::PER_W;

    logic [PER_W-1:0] r_minute_period;
    logic [PER_W-1:0] r_hour_period;
    logic [PER_W-1:0] r_min_cnt;
    logic [PER_W-1:0] r_hour_cnt;
    logic             r_mstore;
    logic             r_hstore;
    shd_pkg::t_in_beat r_in;

    logic [CO2_W-1:0] r_sh_co2 [DEPTH];
    logic [PCT_W-1:0] r_sh_hum [DEPTH];
    logic [PCT_W-1:0] r_sh_tmp [DEPTH];
    logic [CO2_W-1:0] r_lg_co2 [DEPTH];
    logic [PCT_W-1:0] r_lg_hum [DEPTH];
    logic [PCT_W-1:0] r_lg_tmp [DEPTH];

    logic [IDX_W-1:0]                r_sum_idx;
    logic [shd_pkg::CO2_SUM_W-1:0]   r_sum_co2;
    logic [shd_pkg::PCT_SUM_W-1:0]   r_sum_hum;
    logic [shd_pkg::PCT_SUM_W-1:0]   r_sum_tmp;
    logic [shd_pkg::PROD_CO2_W-1:0]  r_prod_co2;
    logic [shd_pkg::PROD_PCT_W-1:0]  r_prod_hum;
    logic [shd_pkg::PROD_PCT_W-1:0]  r_prod_tmp;

    logic               r_out_valid;
    shd_pkg::t_out_beat r_out;

    logic [PER_W-1:0] min_inc;
    logic [PER_W-1:0] hour_inc;
    logic             min_hit;
    logic             hour_hit;
    logic [IDX_W-1:0] addr;
    logic             rd_ok;
    logic             out_busy;
    logic [PCT_W-1:0] new_tmp;
    shd_pkg::t_out_beat read_beat;
    shd_pkg::t_out_beat tick_beat;

    assign min_inc  = r_min_cnt + PER_W'(1);
    assign hour_inc = r_hour_cnt + PER_W'(1);
    assign min_hit  = min_inc >= r_minute_period;
    assign hour_hit = hour_inc >= r_hour_period;
    assign new_tmp  = r_in.temp_negative ? '0 : r_in.temp_magnitude;

    assign addr  = i_ctrl.sum_acc ? r_sum_idx : IDX_W'(r_in.read_index);
    assign rd_ok = 32'(r_in.read_index) < 32'(DEPTH);

    assign out_busy = r_out_valid && i_out_stall;

    always_comb begin
        read_beat = '0;
        if (rd_ok) begin
            if (r_in.read_long_term) begin
                read_beat.co2_out         = r_lg_co2[addr];
                read_beat.humidity_out    = r_lg_hum[addr];
                read_beat.temperature_out = r_lg_tmp[addr];
            end else begin
                read_beat.co2_out         = r_sh_co2[addr];
                read_beat.humidity_out    = r_sh_hum[addr];
                read_beat.temperature_out = r_sh_tmp[addr];
            end
        end
    end

    always_comb begin
        tick_beat.co2_out         = r_lg_co2[0];
        tick_beat.humidity_out    = r_lg_hum[0];
        tick_beat.temperature_out = r_lg_tmp[0];
        tick_beat.minute_stored   = r_mstore;
        tick_beat.hour_stored     = r_hstore;
    end

    // configuration and period counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute_period <= shd_pkg::MINUTE_PERIOD_RST;
            r_hour_period   <= shd_pkg::HOUR_PERIOD_RST;
            r_min_cnt       <= '0;
            r_hour_cnt      <= '0;
            r_mstore        <= 1'b0;
            r_hstore        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    shd_pkg::CFG_MINUTE_PERIOD: r_minute_period <= i_cfg_data;
                    shd_pkg::CFG_HOUR_PERIOD:   r_hour_period   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_fire) begin
                if (i_in_beat.op == shd_pkg::OP_TICK) begin
                    r_min_cnt  <= min_hit ? '0 : min_inc;
                    r_hour_cnt <= hour_hit ? '0 : hour_inc;
                    r_mstore   <= min_hit;
                    r_hstore   <= hour_hit;
                end else begin
                    r_mstore <= 1'b0;
                    r_hstore <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_in <= i_in_beat;
        end
    end

    // history shift lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_sh_co2[k] <= '0;
                r_sh_hum[k] <= '0;
                r_sh_tmp[k] <= '0;
                r_lg_co2[k] <= '0;
                r_lg_hum[k] <= '0;
                r_lg_tmp[k] <= '0;
            end
        end else begin
            if (i_ctrl.shift_short) begin
                for (int k = DEPTH - 1; k > 0; k--) begin
                    r_sh_co2[k] <= r_sh_co2[k-1];
                    r_sh_hum[k] <= r_sh_hum[k-1];
                    r_sh_tmp[k] <= r_sh_tmp[k-1];
                end
                r_sh_co2[0] <= r_in.co2_ppm;
                r_sh_hum[0] <= r_in.humidity_pct;
                r_sh_tmp[0] <= new_tmp;
            end
            if (i_ctrl.shift_long) begin
                for (int k = DEPTH - 1; k > 0; k--) begin
                    r_lg_co2[k] <= r_lg_co2[k-1];
                    r_lg_hum[k] <= r_lg_hum[k-1];
                    r_lg_tmp[k] <= r_lg_tmp[k-1];
                end
                r_lg_co2[0] <= r_prod_co2[shd_pkg::RCP_SH +: CO2_W];
                r_lg_hum[0] <= r_prod_hum[shd_pkg::RCP_SH +: PCT_W];
                r_lg_tmp[0] <= r_prod_tmp[shd_pkg::RCP_SH +: PCT_W];
            end
        end
    end

    // serial sum of the short-term entries, then multiply by the reciprocal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_idx <= '0;
        end else if (i_ctrl.sum_clr) begin
            r_sum_idx <= '0;
        end else if (i_ctrl.sum_acc) begin
            r_sum_idx <= r_sum_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_clr) begin
            r_sum_co2 <= '0;
            r_sum_hum <= '0;
            r_sum_tmp <= '0;
        end else if (i_ctrl.sum_acc) begin
            r_sum_co2 <= r_sum_co2 + shd_pkg::CO2_SUM_W'(r_sh_co2[addr]);
            r_sum_hum <= r_sum_hum + shd_pkg::PCT_SUM_W'(r_sh_hum[addr]);
            r_sum_tmp <= r_sum_tmp + shd_pkg::PCT_SUM_W'(r_sh_tmp[addr]);
        end
        if (i_ctrl.mul) begin
            r_prod_co2 <= shd_pkg::PROD_CO2_W'(r_sum_co2) * shd_pkg::PROD_CO2_W'(shd_pkg::RCP);
            r_prod_hum <= shd_pkg::PROD_PCT_W'(r_sum_hum) * shd_pkg::PROD_PCT_W'(shd_pkg::RCP);
            r_prod_tmp <= shd_pkg::PROD_PCT_W'(r_sum_tmp) * shd_pkg::PROD_PCT_W'(shd_pkg::RCP);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit && !out_busy) begin
            r_out <= i_ctrl.emit_read ? read_beat : tick_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    assign o_stat.in_fire  = i_in_fire;
    assign o_stat.is_read  = r_in.op == shd_pkg::OP_READ;
    assign o_stat.mstore   = r_mstore;
    assign o_stat.hstore   = r_hstore;
    assign o_stat.sum_last = r_sum_idx == IDX_W'(DEPTH - 1);
    assign o_stat.out_busy = out_busy;

endmodule

### design/sensor_history_decimator_unit.sv
// ============================================================================
// sensor_history_decimator_unit
// Minute and hour decimation of CO2, humidity and temperature samples into
// short-term and long-term histories, with entry read-back.
// ============================================================================
// One beat is taken at a time, and the input is stalled while reset is held.
// A read passes from the dispatch step to the read-out step, which loads the
// result register. A tick passes the minute check, a minute push when the
// minute period elapses, and the hour check on its way to the tick output step.
// When the hour period elapses it also runs the serial sum, which visits one
// short-term entry per cycle, before one reciprocal multiply forms the three
// means. A new beat is taken in the cycle after a result enters the output
// register, even if that result is still waiting to be taken. There is no
// clearing pass after reset: all histories are zero at once.
module sensor_history_decimator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  shd_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output shd_pkg::t_out_beat            o_out_beat,
    input  logic                          i_cfg_we,
    input  logic [shd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [shd_pkg::PER_W-1:0]     i_cfg_data
);

    shd_pkg::t_ctrl ctrl;
    shd_pkg::t_stat stat;
    logic           in_fire;

    assign o_in_stall = !i_rst_n || (ctrl.cond != shd_pkg::C_NO_BEAT);
    assign in_fire    = i_in_valid && !o_in_stall;

    shd_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    shd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_fire   (in_fire),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    // one beat in flight at a time
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_in_stall
    ) else $error("beat accepted while previous one still in work");

    // a result only appears from an emit step
    a_result_from_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl.emit)
    ) else $error("result register loaded outside an emit step");

    // summing never overlaps with taking a beat
    a_sum_not_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ctrl.sum_acc |-> o_in_stall
    ) else $error("sum step while input open");

endmodule
